### hw/rtl/ssop_pkg.sv
// shared types, constants and helper functions for the servo slew/overshoot positioner
// no dependencies; every rtl file refers to this package by scoped names

package ssop_pkg;

   localparam int unsigned CmdW   = 3;
   localparam int unsigned AngleW = 8;
   localparam int unsigned LevelW = 16;
   localparam int unsigned HoldW  = 16;
   localparam int unsigned AddrW  = 5;
   localparam int unsigned DataW  = 32;

   localparam logic [LevelW-1:0] LevelBase  = 16'd600;
   localparam logic [LevelW-1:0] LevelReset = 16'd600;
   localparam logic signed [9:0] ShootMax   = 10'sd10;
   localparam logic signed [9:0] ShootMin   = -10'sd10;

   localparam logic [AngleW-1:0] MinReset    = 8'd0;
   localparam logic [AngleW-1:0] MaxReset    = 8'd180;
   localparam logic [AngleW-1:0] OffsetReset = 8'd0;
   localparam logic [AngleW-1:0] StepReset   = 8'd1;
   localparam logic [HoldW-1:0]  HoldReset   = 16'd100;

   typedef enum logic [CmdW-1:0] {
      CMD_SET_NOW    = 3'd0,
      CMD_SET_TARGET = 3'd1,
      CMD_STEP       = 3'd2,
      CMD_OVERSHOOT  = 3'd3,
      CMD_TICK       = 3'd4,
      CMD_START      = 3'd5,
      CMD_STOP       = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ANGLE_MIN  = 3'd0,
      REG_ANGLE_MAX  = 3'd1,
      REG_OFFSET     = 3'd2,
      REG_SLEW_STEP  = 3'd3,
      REG_HOLD_MS    = 3'd4
   } reg_type;

   typedef struct packed {
      logic [AngleW-1:0]        angle_min;
      logic [AngleW-1:0]        angle_max;
      logic signed [AngleW-1:0] angle_offset;
      logic [AngleW-1:0]        slew_step;
      logic [HoldW-1:0]         hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [LevelW-1:0] pwm_level;
      logic              level_written;
      logic              pwm_enabled;
      logic [AngleW-1:0] present_angle;
      logic              hold_active;
   } rsp_type;

   // when the limits cross, values above max clamp to max and all others to min
   function automatic logic [AngleW-1:0] clamp_angle(input logic [AngleW-1:0] v,
                                                     input cfg_type cfg);
      logic [AngleW-1:0] r;
      if (v > cfg.angle_max) begin
         r = cfg.angle_max;
      end else if (v < cfg.angle_min) begin
         r = cfg.angle_min;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // 600 + 14 * max(angle + offset, 0)
   function automatic logic [LevelW-1:0] level_of(input logic signed [9:0] angle,
                                                  input logic signed [AngleW-1:0] offset);
      logic signed [9:0] sum;
      logic [8:0]        mag;
      logic [LevelW-1:0] wide;
      sum  = angle + $signed({{2{offset[AngleW-1]}}, offset});
      mag  = sum[9] ? 9'd0 : sum[8:0];
      wide = {7'd0, mag};
      return LevelBase + (wide << 4) - (wide << 1);
   endfunction

endpackage

### hw/rtl/servo_slew_overshoot_positioner.sv
// Servo positioner: each accepted command beat produces exactly one result beat carrying
// the PWM compare level, whether the level was written, the run flag, the current angle
// and the hold-timer status. A command is held in the input register and its result is then
// registered in the result register; one command per cycle is sustained while the receiver
// does not stall, limited by the single state-update stage that every command passes
// through. Register writes take effect for commands that fire after the write, including
// ones already waiting in the input register; no clearing pass follows reset.
// uses ssop_pkg, ssop_csr and ssop_core

module servo_slew_overshoot_positioner (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ssop_pkg::CmdW-1:0]   req_cmd,
   input  logic [ssop_pkg::AngleW-1:0] req_angle_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ssop_pkg::LevelW-1:0] rsp_pwm_level,
   output logic                        rsp_level_written,
   output logic                        rsp_pwm_enabled,
   output logic [ssop_pkg::AngleW-1:0] rsp_present_angle,
   output logic                        rsp_hold_active,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ssop_pkg::AddrW-1:0]  csr_paddr,
   input  logic [ssop_pkg::DataW-1:0]  csr_pwdata,
   output logic [ssop_pkg::DataW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   ssop_pkg::cfg_type           cfg;
   ssop_pkg::rsp_type           rsp_next;
   ssop_pkg::rsp_type           rsp_data_ff;

   logic                        stage_valid_ff;
   logic [ssop_pkg::CmdW-1:0]   stage_cmd_ff;
   logic [ssop_pkg::AngleW-1:0] stage_angle_ff;
   logic                        rsp_valid_ff;
   logic                        advance;
   logic                        fire;

   // result register free or being drained this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && advance;
   assign req_stall = stage_valid_ff && !advance;

   ssop_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssop_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cmd         (stage_cmd_ff),
      .angle_value (stage_angle_ff),
      .cfg         (cfg),
      .rsp         (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (!req_stall) begin
            stage_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_cmd_ff   <= req_cmd;
         stage_angle_ff <= req_angle_value;
      end
      if (fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_level     = rsp_data_ff.pwm_level;
   assign rsp_level_written = rsp_data_ff.level_written;
   assign rsp_pwm_enabled   = rsp_data_ff.pwm_enabled;
   assign rsp_present_angle = rsp_data_ff.present_angle;
   assign rsp_hold_active   = rsp_data_ff.hold_active;

endmodule

### hw/rtl/ssop_csr.sv
// register file for the positioner limits, trim, slew step and hold length
// apb-style write/read port; uses ssop_pkg

module ssop_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ssop_pkg::AddrW-1:0]  csr_paddr,
   input  logic [ssop_pkg::DataW-1:0]  csr_pwdata,
   output logic [ssop_pkg::DataW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output ssop_pkg::cfg_type           cfg
);

   ssop_pkg::cfg_type cfg_ff;
   ssop_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ssop_pkg::REG_ANGLE_MIN: cfg_in.angle_min    = csr_pwdata[7:0];
            ssop_pkg::REG_ANGLE_MAX: cfg_in.angle_max    = csr_pwdata[7:0];
            ssop_pkg::REG_OFFSET:    cfg_in.angle_offset = $signed(csr_pwdata[7:0]);
            ssop_pkg::REG_SLEW_STEP: cfg_in.slew_step    = csr_pwdata[7:0];
            ssop_pkg::REG_HOLD_MS:   cfg_in.hold_ms      = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ssop_pkg::REG_ANGLE_MIN: csr_prdata = {24'd0, cfg_ff.angle_min};
         ssop_pkg::REG_ANGLE_MAX: csr_prdata = {24'd0, cfg_ff.angle_max};
         ssop_pkg::REG_OFFSET:    csr_prdata = {24'd0, cfg_ff.angle_offset};
         ssop_pkg::REG_SLEW_STEP: csr_prdata = {24'd0, cfg_ff.slew_step};
         ssop_pkg::REG_HOLD_MS:   csr_prdata = {16'd0, cfg_ff.hold_ms};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_min    <= ssop_pkg::MinReset;
         cfg_ff.angle_max    <= ssop_pkg::MaxReset;
         cfg_ff.angle_offset <= $signed(ssop_pkg::OffsetReset);
         cfg_ff.slew_step    <= ssop_pkg::StepReset;
         cfg_ff.hold_ms      <= ssop_pkg::HoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/ssop_core.sv
// positioner state (angles, hold timer, level, run flag) and its per-command update
// uses ssop_pkg; the new state and the result come out of one pass of logic

module ssop_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [ssop_pkg::CmdW-1:0]   cmd,
   input  logic [ssop_pkg::AngleW-1:0] angle_value,
   input  ssop_pkg::cfg_type           cfg,
   output ssop_pkg::rsp_type           rsp
);

   logic [ssop_pkg::AngleW-1:0] cur_ff,    cur_in;
   logic [ssop_pkg::AngleW-1:0] tgt_ff,    tgt_in;
   logic [ssop_pkg::HoldW-1:0]  hold_ff,   hold_in;
   logic [ssop_pkg::LevelW-1:0] level_ff,  level_in;
   logic                        run_ff,    run_in;

   logic [ssop_pkg::AngleW-1:0] req_clamped;
   logic [ssop_pkg::AngleW-1:0] step_size;
   logic [ssop_pkg::AngleW-1:0] dist_abs;
   logic [ssop_pkg::AngleW-1:0] move;
   logic [ssop_pkg::AngleW-1:0] step_next;
   logic signed [9:0]           diff;
   logic signed [9:0]           diff_adj;
   logic signed [9:0]           shoot_raw;
   logic signed [9:0]           shoot;
   logic signed [9:0]           shoot_angle;
   logic [ssop_pkg::HoldW-1:0]  hold_dec;
   logic [ssop_pkg::HoldW-1:0]  hold_load;
   logic                        drive_en;
   logic [ssop_pkg::AngleW-1:0] drive_src;
   logic [ssop_pkg::AngleW-1:0] drive_angle;
   logic                        written;

   assign req_clamped = ssop_pkg::clamp_angle(angle_value, cfg);

   // slew step toward target
   assign step_size = (cfg.slew_step == '0) ? 8'd1 : cfg.slew_step;
   assign dist_abs  = (cur_ff > tgt_ff) ? (cur_ff - tgt_ff) : (tgt_ff - cur_ff);
   assign move      = (dist_abs < step_size) ? dist_abs : step_size;
   assign step_next = (cur_ff > tgt_ff) ? (cur_ff - move) : (cur_ff + move);

   // quarter of the distance, truncated toward zero, limited to +/-10
   assign diff      = $signed({2'b00, req_clamped}) - $signed({2'b00, cur_ff});
   assign diff_adj  = diff + (diff[9] ? 10'sd3 : 10'sd0);
   assign shoot_raw = diff_adj >>> 2;
   always_comb begin
      priority if (shoot_raw > ssop_pkg::ShootMax) begin
         shoot = ssop_pkg::ShootMax;
      end else if (shoot_raw < ssop_pkg::ShootMin) begin
         shoot = ssop_pkg::ShootMin;
      end else begin
         shoot = shoot_raw;
      end
   end
   assign shoot_angle = $signed({2'b00, req_clamped}) + shoot;

   assign hold_dec  = hold_ff - 16'd1;
   assign hold_load = (cfg.hold_ms == '0) ? 16'd1 : cfg.hold_ms;

   always_comb begin
      tgt_in    = tgt_ff;
      hold_in   = hold_ff;
      run_in    = run_ff;
      drive_en  = 1'b0;
      drive_src = cur_ff;
      written   = 1'b0;
      unique case (cmd)
         ssop_pkg::CMD_SET_NOW: begin
            drive_en  = 1'b1;
            drive_src = angle_value;
         end
         ssop_pkg::CMD_SET_TARGET: begin
            tgt_in = req_clamped;
         end
         ssop_pkg::CMD_STEP: begin
            if (cur_ff != tgt_ff) begin
               drive_en  = 1'b1;
               drive_src = step_next;
            end
         end
         ssop_pkg::CMD_OVERSHOOT: begin
            tgt_in  = req_clamped;
            hold_in = hold_load;
            written = 1'b1;
         end
         ssop_pkg::CMD_TICK: begin
            if (hold_ff != '0) begin
               hold_in = hold_dec;
               if (hold_dec == '0) begin
                  drive_en  = 1'b1;
                  drive_src = tgt_ff;
               end
            end
         end
         ssop_pkg::CMD_START: begin
            run_in    = 1'b1;
            drive_en  = 1'b1;
            drive_src = cur_ff;
         end
         ssop_pkg::CMD_STOP: begin
            run_in = 1'b0;
         end
         default: ;
      endcase
   end

   assign drive_angle = ssop_pkg::clamp_angle(drive_src, cfg);

   always_comb begin
      cur_in   = cur_ff;
      level_in = level_ff;
      if (drive_en) begin
         cur_in   = drive_angle;
         level_in = ssop_pkg::level_of($signed({2'b00, drive_angle}), cfg.angle_offset);
      end else if (cmd == ssop_pkg::CMD_OVERSHOOT) begin
         // overshoot position is driven unclamped, current angle stays
         level_in = ssop_pkg::level_of(shoot_angle, cfg.angle_offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         tgt_ff   <= '0;
         hold_ff  <= '0;
         level_ff <= ssop_pkg::LevelReset;
         run_ff   <= 1'b0;
      end else if (fire) begin
         cur_ff   <= cur_in;
         tgt_ff   <= tgt_in;
         hold_ff  <= hold_in;
         level_ff <= level_in;
         run_ff   <= run_in;
      end
   end

   assign rsp.pwm_level     = level_in;
   assign rsp.level_written = written || drive_en;
   assign rsp.pwm_enabled   = run_in;
   assign rsp.present_angle = cur_in;
   assign rsp.hold_active   = (hold_in != '0);

endmodule

### hw/rtl/ssop_checker.sv
// port-level checks for the servo positioner, bound onto the top level
// uses ssop_pkg; sees the top-level ports only

module ssop_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [ssop_pkg::CmdW-1:0]   req_cmd,
   input logic [ssop_pkg::AngleW-1:0] req_angle_value,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ssop_pkg::LevelW-1:0] rsp_pwm_level,
   input logic                        rsp_level_written,
   input logic                        rsp_pwm_enabled,
   input logic [ssop_pkg::AngleW-1:0] rsp_present_angle,
   input logic                        rsp_hold_active,
   input logic                        csr_psel,
   input logic                        csr_penable,
   input logic                        csr_pwrite,
   input logic [ssop_pkg::AddrW-1:0]  csr_paddr,
   input logic [ssop_pkg::DataW-1:0]  csr_pwdata,
   input logic [ssop_pkg::DataW-1:0]  csr_prdata,
   input logic                        csr_pready
);

   // after reset nothing is pending on either side
   property p_reset_empty;
      @(posedge clock) reset |=> (!rsp_valid && !req_stall);
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("pipeline not empty after reset");

   // an empty result register always lets the input stage move on
   property p_no_stall_when_empty;
      @(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall;
   endproperty
   a_no_stall_when_empty: assert property (p_no_stall_when_empty)
      else $error("input stalled while result register empty");

   // level stays within 600 .. 600 + 392 * 14
   property p_level_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_pwm_level >= 16'd600 && rsp_pwm_level <= 16'd6088);
   endproperty
   a_level_range: assert property (p_level_range)
      else $error("compare level out of range");

   // stalled result beat holds
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pwm_level)
            && $stable(rsp_level_written) && $stable(rsp_pwm_enabled)
            && $stable(rsp_present_angle) && $stable(rsp_hold_active));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled result beat changed");

endmodule

bind servo_slew_overshoot_positioner ssop_checker u_ssop_checker (.*);

### tb/sv/servo_slew_overshoot_positioner_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the servo slew/overshoot positioner: commands go in through a
// queue-fed driver, a shadow positioner predicts every status beat and the monitor checks it
// depends on ssop_pkg and servo_slew_overshoot_positioner

module servo_slew_overshoot_positioner_tb;
   import ssop_pkg::*;

   localparam int LevelPerDegree = 14;
   localparam int ShootDivisor   = 4;
   localparam int LongHoldOff    = 300;
   localparam int StallLimit     = 3000;
   localparam int RandomPhases   = 8;
   localparam int PhaseBeats     = 125;
   localparam logic [CmdW-1:0] CmdUnused = 3'd7;

   typedef struct {
      logic [CmdW-1:0]   cmd;
      logic [AngleW-1:0] angle;
   } servo_cmd_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CmdW-1:0]     req_cmd = '0;
   logic [AngleW-1:0]   req_angle_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LevelW-1:0]   rsp_pwm_level;
   logic                rsp_level_written;
   logic                rsp_pwm_enabled;
   logic [AngleW-1:0]   rsp_present_angle;
   logic                rsp_hold_active;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [AddrW-1:0]    csr_paddr = '0;
   logic [DataW-1:0]    csr_pwdata = '0;
   logic [DataW-1:0]    csr_prdata;
   logic                csr_pready;

   servo_slew_overshoot_positioner uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_angle_value(req_angle_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pwm_level(rsp_pwm_level), .rsp_level_written(rsp_level_written),
      .rsp_pwm_enabled(rsp_pwm_enabled), .rsp_present_angle(rsp_present_angle),
      .rsp_hold_active(rsp_hold_active),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // shadow of the positioner
   cfg_type           shadow_cfg;
   logic [AngleW-1:0] cur_angle;
   logic [AngleW-1:0] tgt_angle;
   logic [HoldW-1:0]  hold_left;
   logic [LevelW-1:0] level_now;
   logic              motor_on;

   servo_cmd_type cmd_backlog[$];
   rsp_type       status_due[$];
   servo_cmd_type driver_beat;
   int          send_gap;
   int          stall_left;
   int          fault_count = 0;
   int          idle_cycles;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;
   bit          hold_off_req = 1'b0;
   bit          hold_off_taken;

   function automatic logic [AngleW-1:0] limit_angle(input int v);
      if (v > int'(shadow_cfg.angle_max)) begin
         return shadow_cfg.angle_max;
      end
      if (v < int'(shadow_cfg.angle_min)) begin
         return shadow_cfg.angle_min;
      end
      return AngleW'(v);
   endfunction

   function automatic logic [LevelW-1:0] level_for(input int angle);
      int s;
      s = angle + int'($signed(shadow_cfg.angle_offset));
      if (s < 0) begin
         s = 0;
      end
      return LevelW'(int'(LevelBase) + s * LevelPerDegree);
   endfunction

   function automatic void move_to(input int v);
      cur_angle = limit_angle(v);
      level_now = level_for(int'(cur_angle));
   endfunction

   function automatic rsp_type servo_advance(input logic [CmdW-1:0] cmd,
                                             input logic [AngleW-1:0] ang);
      rsp_type           r;
      logic              wrote;
      int                span;
      int                remaining;
      int                shoot;
      logic [AngleW-1:0] a;
      wrote = 1'b0;
      case (cmd)
         CMD_SET_NOW: begin
            move_to(int'(ang));
            wrote = 1'b1;
         end
         CMD_SET_TARGET: begin
            tgt_angle = limit_angle(int'(ang));
         end
         CMD_STEP: begin
            if (cur_angle != tgt_angle) begin
               // a zero slew step still moves one degree
               span = (shadow_cfg.slew_step == 0) ? 1 : int'(shadow_cfg.slew_step);
               remaining = (cur_angle > tgt_angle) ? int'(cur_angle) - int'(tgt_angle)
                                                   : int'(tgt_angle) - int'(cur_angle);
               if (remaining < span) begin
                  span = remaining;
               end
               move_to((cur_angle > tgt_angle) ? int'(cur_angle) - span
                                               : int'(cur_angle) + span);
               wrote = 1'b1;
            end
         end
         CMD_OVERSHOOT: begin
            a = limit_angle(int'(ang));
            shoot = (int'(a) - int'(cur_angle)) / ShootDivisor;
            if (shoot > int'(ShootMax)) begin
               shoot = int'(ShootMax);
            end else if (shoot < int'(ShootMin)) begin
               shoot = int'(ShootMin);
            end
            // overshoot angle is not clamped to the limits
            level_now = level_for(int'(a) + shoot);
            tgt_angle = a;
            hold_left = (shadow_cfg.hold_ms == 0) ? HoldW'(1) : shadow_cfg.hold_ms;
            wrote = 1'b1;
         end
         CMD_TICK: begin
            if (hold_left != 0) begin
               hold_left = hold_left - 1'b1;
               if (hold_left == 0) begin
                  move_to(int'(tgt_angle));
                  wrote = 1'b1;
               end
            end
         end
         CMD_START: begin
            motor_on = 1'b1;
            move_to(int'(cur_angle));
            wrote = 1'b1;
         end
         CMD_STOP: begin
            motor_on = 1'b0;
         end
         default: begin
         end
      endcase
      r.pwm_level     = level_now;
      r.level_written = wrote;
      r.pwm_enabled   = motor_on;
      r.present_angle = cur_angle;
      r.hold_active   = (hold_left != 0);
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            status_due.push_back(servo_advance(req_cmd, req_angle_value));
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               driver_beat = cmd_backlog.pop_front();
               req_valid <= 1'b1;
               req_cmd <= driver_beat.cmd;
               req_angle_value <= driver_beat.angle;
               send_gap = send_calm ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, including the one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_off_taken = 1'b0;
      end else begin
         if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            stall_left = LongHoldOff;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!recv_calm && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $error("status beat with no command outstanding");
            fault_count++;
         end else begin
            want = status_due.pop_front();
            if (rsp_pwm_level !== want.pwm_level) begin
               $error("pwm_level expected %0d got %0d", want.pwm_level, rsp_pwm_level);
               fault_count++;
            end
            if (rsp_level_written !== want.level_written) begin
               $error("level_written expected %0b got %0b", want.level_written,
                      rsp_level_written);
               fault_count++;
            end
            if (rsp_pwm_enabled !== want.pwm_enabled) begin
               $error("pwm_enabled expected %0b got %0b", want.pwm_enabled, rsp_pwm_enabled);
               fault_count++;
            end
            if (rsp_present_angle !== want.present_angle) begin
               $error("present_angle expected %0d got %0d", want.present_angle,
                      rsp_present_angle);
               fault_count++;
            end
            if (rsp_hold_active !== want.hold_active) begin
               $error("hold_active expected %0b got %0b", want.hold_active, rsp_hold_active);
               fault_count++;
            end
         end
      end
   end

   // watchdog on cycles where no beat moves anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("FAIL servo_slew_overshoot_positioner");
            $finish;
         end
      end
   end

   task automatic csr_write(input reg_type idx, input logic [DataW-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ANGLE_MIN: shadow_cfg.angle_min = value[AngleW-1:0];
         REG_ANGLE_MAX: shadow_cfg.angle_max = value[AngleW-1:0];
         REG_OFFSET:    shadow_cfg.angle_offset = value[AngleW-1:0];
         REG_SLEW_STEP: shadow_cfg.slew_step = value[AngleW-1:0];
         REG_HOLD_MS:   shadow_cfg.hold_ms = value[HoldW-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(input int lo, input int hi, input int trim, input int stride,
                                 input int hold);
      csr_write(REG_ANGLE_MIN, DataW'(AngleW'(lo)));
      csr_write(REG_ANGLE_MAX, DataW'(AngleW'(hi)));
      csr_write(REG_OFFSET, DataW'(AngleW'(trim)));
      csr_write(REG_SLEW_STEP, DataW'(AngleW'(stride)));
      csr_write(REG_HOLD_MS, DataW'(HoldW'(hold)));
   endtask

   // block must be drained before touching the registers
   task automatic wait_idle();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || status_due.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_command(input logic [CmdW-1:0] cmd, input logic [AngleW-1:0] ang);
      servo_cmd_type c;
      c.cmd = cmd;
      c.angle = ang;
      cmd_backlog.push_back(c);
   endtask

   function automatic logic [AngleW-1:0] pick_angle();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 2))
            0: return 8'd0;
            1: return 8'd180;
            default: return 8'd255;
         endcase
      end
      if (r < 3) begin
         return AngleW'($urandom_range(0, 255));
      end
      return AngleW'($urandom_range(0, 190));
   endfunction

   task automatic queue_random_commands(input int count);
      int queued;
      int r;
      int n;
      queued = 0;
      while (queued < count) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            // overshoot then ticks that, for holds up to 16, may run its hold out and past expiry
            queue_command(CMD_OVERSHOOT, pick_angle());
            n = (shadow_cfg.hold_ms <= 16) ? $urandom_range(1, int'(shadow_cfg.hold_ms) + 2)
                                           : $urandom_range(1, 4);
            repeat (n) queue_command(CMD_TICK, AngleW'($urandom_range(0, 255)));
            queued += 1 + n;
         end else if (r < 22) begin
            queue_command(CMD_SET_TARGET, pick_angle());
            n = $urandom_range(1, 8);
            repeat (n) queue_command(CMD_STEP, AngleW'($urandom_range(0, 255)));
            queued += 1 + n;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               queue_command(CMD_SET_NOW, pick_angle());
            end else if (r < 22) begin
               queue_command(CMD_SET_TARGET, pick_angle());
            end else if (r < 47) begin
               queue_command(CMD_STEP, pick_angle());
            end else if (r < 55) begin
               queue_command(CMD_OVERSHOOT, pick_angle());
            end else if (r < 85) begin
               queue_command(CMD_TICK, pick_angle());
            end else if (r < 91) begin
               queue_command(CMD_START, pick_angle());
            end else if (r < 97) begin
               queue_command(CMD_STOP, pick_angle());
            end else begin
               queue_command(CmdUnused, pick_angle());
            end
            queued++;
         end
      end
   endtask

   initial begin
      int p;
      int lo;
      int hi;
      int stride;
      int hold;
      shadow_cfg.angle_min = MinReset;
      shadow_cfg.angle_max = MaxReset;
      shadow_cfg.angle_offset = OffsetReset;
      shadow_cfg.slew_step = StepReset;
      shadow_cfg.hold_ms = HoldReset;
      cur_angle = '0;
      tgt_angle = '0;
      hold_left = '0;
      level_now = LevelReset;
      motor_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clamping, slew, overshoot limits, stop while stopped
      @(negedge clock);
      queue_command(CMD_STOP, 8'h00);
      queue_command(CMD_SET_NOW, 8'hFF);
      queue_command(CMD_START, 8'h00);
      queue_command(CMD_SET_TARGET, 8'hAA);
      queue_command(CMD_STEP, 8'h00);
      queue_command(CMD_OVERSHOOT, 8'h00);
      queue_command(CMD_TICK, 8'hFF);
      queue_command(CMD_OVERSHOOT, 8'h55);
      queue_command(CMD_OVERSHOOT, 8'hB4);
      queue_command(CMD_STEP, 8'h00);
      queue_command(CMD_STEP, 8'h00);
      queue_command(CMD_STOP, 8'h00);
      queue_command(CMD_SET_NOW, 8'h25);
      queue_command(CmdUnused, 8'hAA);
      queue_command(CMD_OVERSHOOT, 8'h7F);
      wait_idle();

      // negative trim, zero slew step and zero hold length
      apply_settings(20, 160, -90, 0, 0);
      @(negedge clock);
      queue_command(CMD_SET_NOW, 8'h05);
      queue_command(CMD_SET_NOW, 8'hC8);
      queue_command(CMD_SET_TARGET, 8'h00);
      queue_command(CMD_STEP, 8'h00);
      queue_command(CMD_OVERSHOOT, 8'h64);
      queue_command(CMD_TICK, 8'h00);
      queue_command(CMD_TICK, 8'h00);
      wait_idle();

      // crossed limits: values above max clamp to max, all others to min
      apply_settings(150, 30, 90, 180, 3);
      @(negedge clock);
      queue_command(CMD_SET_NOW, 8'h0A);
      queue_command(CMD_SET_NOW, 8'hF0);
      queue_command(CMD_SET_TARGET, 8'h80);
      wait_idle();

      for (p = 0; p < RandomPhases; p++) begin
         if (p == 0) begin
            apply_settings(0, 180, 90, 180, 65535);
         end else if (p == 1) begin
            apply_settings(180, 0, -90, 1, 1);
         end else begin
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 180) : $urandom_range(0, 60);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 180)
                                             : $urandom_range(120, 180);
            stride = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 180)
                                                 : $urandom_range(1, 12);
            hold = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                               : $urandom_range(1, 6);
            apply_settings(lo, hi, int'($urandom_range(0, 180)) - 90, stride, hold);
         end
         @(negedge clock);
         send_calm = (p == 2 || p == 3);
         recv_calm = (p == 5);
         queue_random_commands(PhaseBeats);
         if (p == 3) begin
            // sender keeps offering while the receiver holds off
            hold_off_req = 1'b1;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS servo_slew_overshoot_positioner");
      end else begin
         $display("FAIL servo_slew_overshoot_positioner");
      end
      $finish;
   end

endmodule
